FILE: sv/tbmn_pkg.sv
package tbmn_pkg;

    localparam int DEF_MAX_FACES  = 8;
    localparam int DEF_MAX_APPS   = 16;
    localparam int FACE_FIELD_CAP = 8;
    localparam int APP_FIELD_CAP  = 16;

    localparam int IN_W  = 40;
    localparam int OUT_W = 24;

    localparam logic [15:0] DEF_LONG_PRESS_MS    = 16'd1000;
    localparam logic [15:0] DEF_SLEEP_TIMEOUT_MS = 16'd5000;
    localparam logic [3:0]  DEF_FACE_COUNT       = 4'd3;
    localparam logic [4:0]  DEF_APP_COUNT        = 5'd2;

    typedef enum logic [1:0] {
        CFG_LONG_PRESS    = 2'd0,
        CFG_SLEEP_TIMEOUT = 2'd1,
        CFG_FACE_COUNT    = 2'd2,
        CFG_APP_COUNT     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_FACE = 2'd0,
        MODE_MENU = 2'd1,
        MODE_APP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic down;
        logic rise;
        logic fall;
        logic lng;
    } btn_evt_t;

    // packed msb first: mode lands in the lowest bits
    typedef struct packed {
        logic       sleep_request;
        logic       app_stop;
        logic       app_start;
        logic       face_action_long;
        logic       face_action_short;
        logic       face_restart;
        logic [3:0] app_sel;
        logic [3:0] menu_sel;
        logic [2:0] face_sel;
        mode_t      mode;
    } result_t;

endpackage

FILE: sv/three_button_mode_navigator.sv
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while m_tready is high; the input register refills while a result waits.
// Reset (rst_n low, asynchronous): button history, mode state and both pipeline
// valids clear; configuration registers return to their defaults.
module three_button_mode_navigator
    import tbmn_pkg::*;
#(
    parameter int MAX_FACES = DEF_MAX_FACES,
    parameter int MAX_APPS  = DEF_MAX_APPS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // btn0_pressed, btn1_pressed, btn2_pressed, now_ms[31:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // mode[1:0], face_sel[2:0], menu_sel[3:0], app_sel[3:0],
                                        // face_restart, face_action_short, face_action_long,
                                        // app_start, app_stop, sleep_request
);

    logic [15:0] long_press_reg;
    logic [15:0] sleep_timeout_reg;
    logic [3:0]  face_count_reg;
    logic [4:0]  app_count_reg;

    logic        in_valid_reg;
    logic [34:0] in_data_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;

    logic           advance;
    logic           suppress_set;
    btn_evt_t [2:0] evt;
    result_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= DEF_LONG_PRESS_MS;
            sleep_timeout_reg <= DEF_SLEEP_TIMEOUT_MS;
            face_count_reg    <= DEF_FACE_COUNT;
            app_count_reg     <= DEF_APP_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LONG_PRESS:    long_press_reg    <= cfg_data;
                CFG_SLEEP_TIMEOUT: sleep_timeout_reg <= cfg_data;
                CFG_FACE_COUNT:    face_count_reg    <= cfg_data[3:0];
                CFG_APP_COUNT:     app_count_reg     <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[34:0];
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_btn
        tbmn_btn u_btn (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (advance),
            .level         (in_data_reg[i]),
            .now_ms        (in_data_reg[34:3]),
            .long_press_ms (long_press_reg),
            .suppress_set  (suppress_set),
            .evt           (evt[i])
        );
    end

    tbmn_mode #(
        .MAX_FACES (MAX_FACES),
        .MAX_APPS  (MAX_APPS)
    ) u_mode (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .now_ms           (in_data_reg[34:3]),
        .evt              (evt),
        .sleep_timeout_ms (sleep_timeout_reg),
        .face_count       (face_count_reg),
        .app_count        (app_count_reg),
        .suppress_set     (suppress_set),
        .res              (res)
    );

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending input item dropped");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("waiting result changed");

    a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.app_start && !out_data_reg.app_stop
        |-> out_data_reg.mode == MODE_APP)
        else $error("app start without app mode");

    a_stop_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.app_stop
        |-> out_data_reg.mode == MODE_FACE && out_data_reg.face_restart)
        else $error("app stop without return to face");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

FILE: sv/tbmn_btn.sv
module tbmn_btn
    import tbmn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        level,
    input  logic [31:0] now_ms,
    input  logic [15:0] long_press_ms,
    input  logic        suppress_set,
    output btn_evt_t    evt
);

    logic        prev_reg;
    logic        prev_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic        supp_reg;
    logic        supp_next;
    logic        rise_raw;
    logic        fall_raw;
    logic        long_raw;
    logic        masked;
    logic [31:0] held_ms;

    always_comb
    begin
        rise_raw = !prev_reg && level;
        fall_raw = prev_reg && !level;
        held_ms  = now_ms - start_reg;
        // a fresh press has zero hold time
        long_raw = level && !rise_raw && (held_ms > {16'd0, long_press_ms});
        masked   = supp_reg && level;

        evt.down = level && !masked;
        evt.rise = rise_raw && !masked;
        evt.fall = fall_raw && !masked;
        evt.lng  = long_raw && !masked;

        prev_next  = level;
        start_next = (rise_raw || masked) ? now_ms : start_reg;
        supp_next  = suppress_set || masked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            start_reg <= 32'd0;
            supp_reg  <= 1'b0;
        end
        else if (en)
        begin
            prev_reg  <= prev_next;
            start_reg <= start_next;
            supp_reg  <= supp_next;
        end
    end

endmodule

FILE: sv/tbmn_mode.sv
module tbmn_mode
    import tbmn_pkg::*;
#(
    parameter int MAX_FACES = DEF_MAX_FACES,
    parameter int MAX_APPS  = DEF_MAX_APPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [31:0]        now_ms,
    input  btn_evt_t [2:0]     evt,
    input  logic [15:0]        sleep_timeout_ms,
    input  logic [3:0]         face_count,
    input  logic [4:0]         app_count,
    output logic               suppress_set,
    output result_t            res
);

    localparam int FACE_CAP_I = (MAX_FACES < FACE_FIELD_CAP) ? MAX_FACES : FACE_FIELD_CAP;
    localparam int APP_CAP_I  = (MAX_APPS < APP_FIELD_CAP) ? MAX_APPS : APP_FIELD_CAP;
    localparam logic [3:0] FACE_CAP = 4'(FACE_CAP_I);
    localparam logic [4:0] APP_CAP  = 5'(APP_CAP_I);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [2:0]  face_reg;
    logic [2:0]  face_next;
    logic [3:0]  menu_reg;
    logic [3:0]  menu_next;
    logic [3:0]  app_reg;
    logic [3:0]  app_next;
    logic [31:0] since_reg;
    logic [31:0] since_next;
    logic        since_vld_reg;
    logic        since_vld_next;

    logic [3:0]  fcnt;
    logic [4:0]  acnt;
    logic [31:0] shown_ms;
    logic        restart;
    logic        act_s;
    logic        act_l;
    logic        a_start;
    logic        a_stop;
    logic        sleep;

    always_comb
    begin
        fcnt = (face_count == 4'd0) ? 4'd1 : ((face_count > FACE_CAP) ? FACE_CAP : face_count);
        acnt = (app_count == 5'd0) ? 5'd1 : ((app_count > APP_CAP) ? APP_CAP : app_count);

        mode_next      = mode_reg;
        face_next      = face_reg;
        menu_next      = menu_reg;
        app_next       = app_reg;
        since_next     = since_reg;
        since_vld_next = since_vld_reg;
        suppress_set   = 1'b0;
        restart        = 1'b0;
        act_s          = 1'b0;
        act_l          = 1'b0;
        a_start        = 1'b0;
        a_stop         = 1'b0;
        sleep          = 1'b0;
        shown_ms       = 32'd0;

        unique case (mode_reg)
            MODE_FACE:
            begin
                if (evt[0].down && evt[2].down)
                begin
                    mode_next    = MODE_MENU;
                    suppress_set = 1'b1;
                end
                if (!since_vld_reg)
                begin
                    since_next     = now_ms;
                    since_vld_next = 1'b1;
                end
                if (evt[2].fall)
                begin
                    face_next  = ({1'b0, face_next} + 4'd1 >= fcnt) ? 3'd0 : face_next + 3'd1;
                    restart    = 1'b1;
                    since_next = now_ms;
                end
                if (evt[0].fall)
                begin
                    face_next  = (face_next == 3'd0 || {1'b0, face_next} >= fcnt)
                                 ? 3'(fcnt - 4'd1) : face_next - 3'd1;
                    restart    = 1'b1;
                    since_next = now_ms;
                end
                act_s    = evt[1].rise;
                act_l    = evt[1].lng;
                shown_ms = now_ms - since_next;
                sleep    = (face_next == 3'd0) && (shown_ms > {16'd0, sleep_timeout_ms});
            end
            MODE_MENU:
            begin
                if (evt[2].fall)
                begin
                    menu_next = ({1'b0, menu_next} + 5'd1 >= acnt) ? 4'd0 : menu_next + 4'd1;
                end
                if (evt[0].fall)
                begin
                    menu_next = (menu_next == 4'd0 || {1'b0, menu_next} >= acnt)
                                ? 4'(acnt - 5'd1) : menu_next - 4'd1;
                end
                if (evt[1].fall)
                begin
                    mode_next = MODE_APP;
                    app_next  = menu_next;
                    a_start   = 1'b1;
                end
            end
            MODE_APP:
            begin
            end
            default:
            begin
            end
        endcase

        // return to face runs after the mode handler
        if (evt[0].lng && evt[1].lng)
        begin
            a_stop       = (mode_next == MODE_APP);
            restart      = 1'b1;
            mode_next    = MODE_FACE;
            suppress_set = 1'b1;
        end

        res.mode              = mode_next;
        res.face_sel          = face_next;
        res.menu_sel          = menu_next;
        res.app_sel           = app_next;
        res.face_restart      = restart;
        res.face_action_short = act_s;
        res.face_action_long  = act_l;
        res.app_start         = a_start;
        res.app_stop          = a_stop;
        res.sleep_request     = sleep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FACE;
            face_reg      <= 3'd0;
            menu_reg      <= 4'd0;
            app_reg       <= 4'd0;
            since_reg     <= 32'd0;
            since_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            mode_reg      <= mode_next;
            face_reg      <= face_next;
            menu_reg      <= menu_next;
            app_reg       <= app_next;
            since_reg     <= since_next;
            since_vld_reg <= since_vld_next;
        end
    end

endmodule
